### rtl/core/smi_pkg.sv
`default_nettype none

package smi_pkg;

  // opcodes
  localparam logic [4:0] OP_PUSH = 5'd0;
  localparam logic [4:0] OP_POP  = 5'd1;
  localparam logic [4:0] OP_DUP  = 5'd2;
  localparam logic [4:0] OP_ADD  = 5'd3;
  localparam logic [4:0] OP_SUB  = 5'd4;
  localparam logic [4:0] OP_MUL  = 5'd5;
  localparam logic [4:0] OP_DIV  = 5'd6;
  localparam logic [4:0] OP_JMP  = 5'd7;
  localparam logic [4:0] OP_JIT  = 5'd8;
  localparam logic [4:0] OP_JIF  = 5'd9;
  localparam logic [4:0] OP_CALL = 5'd10;
  localparam logic [4:0] OP_RET  = 5'd11;
  localparam logic [4:0] OP_EQ   = 5'd12;
  localparam logic [4:0] OP_GT   = 5'd13;
  localparam logic [4:0] OP_GE   = 5'd14;
  localparam logic [4:0] OP_LT   = 5'd15;
  localparam logic [4:0] OP_LE   = 5'd16;
  localparam logic [4:0] OP_NE   = 5'd17;
  localparam logic [4:0] OP_STO  = 5'd18;
  localparam logic [4:0] OP_RCL  = 5'd19;
  localparam logic [4:0] OP_END  = 5'd20;
  localparam logic [4:0] OP_PRN  = 5'd21;
  localparam logic [4:0] OP_STL  = 5'd22;
  localparam logic [4:0] OP_RCE  = 5'd23;
  localparam logic [4:0] OP_ALC  = 5'd24;
  localparam logic [4:0] OP_FRE  = 5'd25;

  // operand tags
  localparam logic [2:0] TAG_NUM = 3'd0;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TAG       = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [2:0] ERR_CALL      = 3'd4;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd5;
  localparam logic [2:0] ERR_INDEX     = 3'd6;
  localparam logic [2:0] ERR_UNSUP     = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic read;
    logic div_start;
    logic commit;
    logic call2;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_go;
    logic call_go;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/smi_div.sv
`default_nettype none

module smi_div
  import smi_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  quo;
  logic [W-1:0]  den;
  logic [W-1:0]  rem;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic [W+1:0]  diff;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;

  // operand magnitudes
  assign a_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign b_mag = divisor[W-1] ? (~divisor + W'(1)) : divisor;

  // one restoring step
  assign rem_sh = {rem, quo[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder, the remainder always stays below a nonzero divisor
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= a_mag;
      den <= b_mag;
      rem <= '0;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + W'(1)) : quo;

endmodule

`default_nettype wire

### rtl/core/smi_ctrl.sv
`default_nettype none

module smi_ctrl
  import smi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_READ   = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_CALL2  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // commands
  always_comb begin
    cmd           = '0;
    cmd.load      = in_valid && (state == S_IDLE);
    cmd.decode    = (state == S_DECODE);
    cmd.read      = (state == S_READ);
    cmd.div_start = (state == S_EXEC) && sts.div_go;
    cmd.commit    = ((state == S_EXEC) && !sts.div_go) || ((state == S_DIV) && sts.div_done);
    cmd.call2     = (state == S_CALL2);
    cmd.finish    = (state == S_DONE) && sts.out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = S_READ;
      S_READ:   state_next = S_EXEC;
      S_EXEC: begin
        if (sts.div_go) state_next = S_DIV;
        else if (sts.call_go) state_next = S_CALL2;
        else state_next = S_DONE;
      end
      S_DIV:    if (sts.div_done) state_next = S_DONE;
      S_CALL2:  state_next = S_DONE;
      S_DONE:   if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DECODE) else $error("accepted request did not decode");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !in_ready) else $error("commit while idle");
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !sts.div_done) |=> state == S_DIV) else $error("left divide early");

endmodule

`default_nettype wire

### rtl/core/smi_dp.sv
`default_nettype none

module smi_dp
  import smi_pkg::*;
#(
  parameter int DATA_STACK_DEPTH = 64,
  parameter int CALL_STACK_DEPTH = 128,
  parameter int MEM_DEPTH        = 128,
  parameter int VALUE_WIDTH      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               cfg_write,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [4:0]         opcode,
  input  wire logic [2:0]         arg_type,
  input  wire logic signed [31:0] arg_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             next_ip,
  output logic                    print_valid,
  output logic [2:0]              print_tag,
  output logic signed [31:0]      print_value,
  output logic                    halted,
  output logic                    budget_done,
  output logic [2:0]              error_code
);

  localparam int W   = VALUE_WIDTH;
  localparam int EW  = W + 3;
  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int DCW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int CAW = $clog2(CALL_STACK_DEPTH);
  localparam int CCW = $clog2(CALL_STACK_DEPTH + 1);
  localparam int MAW = $clog2(MEM_DEPTH);

  // architectural state
  logic [15:0]  ip;
  logic [15:0]  fb;
  logic [DCW-1:0] dcnt;
  logic [CCW-1:0] ccnt;
  logic [31:0]  steps;
  logic [31:0]  limit;

  // current instruction
  logic [4:0]   op_q;
  logic [2:0]   tag_q;
  logic [31:0]  arg_q;
  logic [15:0]  ip_old;

  // memories
  logic [EW-1:0] dmem [DATA_STACK_DEPTH];
  logic [EW-1:0] cmem [CALL_STACK_DEPTH];
  logic [EW-1:0] vmem [MEM_DEPTH];
  logic [EW-1:0] d_rdata, c_rdata, v_rdata;
  logic [DAW-1:0] d_raddr;
  logic [CAW-1:0] c_raddr;
  logic [EW-1:0] t_q, c1_q, v_q;

  // results waiting for the output register
  logic [15:0] res_nip;
  logic        res_pv;
  logic [2:0]  res_ptag;
  logic [31:0] res_pval;
  logic        res_halt;
  logic        res_budget;
  logic [2:0]  res_err;

  // decode helpers
  logic [DCW-1:0] dcnt_m1, dcnt_m2;
  logic [CCW-1:0] ccnt_m1, ccnt_m2;
  logic           d_lt1, d_lt2, d_full;
  logic [2:0]     t_tag, s_tag;
  logic [W-1:0]   t_val, s_val;
  logic           mem_ok;
  logic [33:0]    ix_s;
  logic           ix_ok;
  logic [CAW-1:0] cidx;
  logic [33:0]    nc;
  logic           nc_ok;
  logic           call_fault;
  logic           spent;
  logic [W-1:0]   mul_res;
  logic [W-1:0]   quo;
  logic           div_done;
  logic [W-1:0]   alu;
  logic           cmp_r;

  // commit values
  logic [2:0]     err;
  logic [15:0]    nip;
  logic [DCW-1:0] dcnt_next;
  logic [CCW-1:0] ccnt_next;
  logic [15:0]    fb_next;
  logic           halt_c, pv_c;
  logic [2:0]     ptag_c;
  logic [31:0]    pval_c;
  logic           d_we_c, c_we_c, v_we_c;
  logic [DAW-1:0] d_wa;
  logic [EW-1:0]  d_wd;
  logic [CAW-1:0] c_wa;
  logic [EW-1:0]  c_wd;
  logic           div_go, call_go;
  logic           d_we, c_we, v_we;
  logic [CAW-1:0] c_waddr;
  logic [EW-1:0]  c_wdata;

  assign dcnt_m1 = dcnt - DCW'(1);
  assign dcnt_m2 = dcnt - DCW'(2);
  assign ccnt_m1 = ccnt - CCW'(1);
  assign ccnt_m2 = ccnt - CCW'(2);
  assign d_lt1   = (dcnt == '0);
  assign d_lt2   = (dcnt < DCW'(2));
  assign d_full  = (dcnt >= DCW'(DATA_STACK_DEPTH));

  assign t_tag = t_q[EW-1:W];
  assign t_val = t_q[W-1:0];
  assign s_tag = d_rdata[EW-1:W];
  assign s_val = d_rdata[W-1:0];

  // index checks
  assign mem_ok = !arg_q[31] && (arg_q < 32'(MEM_DEPTH));
  assign ix_s   = 34'($signed(arg_q)) + 34'($signed(fb));
  assign ix_ok  = !ix_s[33] && (ix_s[32:0] < 33'(CALL_STACK_DEPTH));
  assign cidx   = ix_s[CAW-1:0];
  assign nc     = (op_q == OP_ALC) ? (34'(ccnt) + 34'($signed(arg_q)))
                                   : (34'(ccnt) - 34'($signed(arg_q)));
  assign nc_ok  = !nc[33] && (nc[32:0] <= 33'(CALL_STACK_DEPTH));
  assign call_fault = ({1'b0, ccnt} + (CCW+1)'(2)) > (CCW+1)'(CALL_STACK_DEPTH);
  assign spent  = (steps >= limit);

  // arithmetic
  assign mul_res = s_val * t_val;

  smi_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (s_val),
    .divisor  (t_val),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    case (op_q)
      OP_ADD:  alu = s_val + t_val;
      OP_SUB:  alu = s_val - t_val;
      OP_MUL:  alu = mul_res;
      default: alu = quo;
    endcase
  end

  // compares, signed
  always_comb begin
    case (op_q)
      OP_EQ:   cmp_r = (s_val == t_val);
      OP_GT:   cmp_r = ($signed(s_val) > $signed(t_val));
      OP_GE:   cmp_r = ($signed(s_val) >= $signed(t_val));
      OP_LT:   cmp_r = ($signed(s_val) < $signed(t_val));
      OP_LE:   cmp_r = ($signed(s_val) <= $signed(t_val));
      default: cmp_r = (s_val != t_val);
    endcase
  end

  // instruction execution
  always_comb begin
    err       = ERR_NONE;
    nip       = ip + 16'd1;
    dcnt_next = dcnt;
    ccnt_next = ccnt;
    fb_next   = fb;
    halt_c    = 1'b0;
    pv_c      = 1'b0;
    ptag_c    = 3'd0;
    pval_c    = 32'd0;
    d_we_c    = 1'b0;
    d_wa      = dcnt[DAW-1:0];
    d_wd      = {tag_q, arg_q[W-1:0]};
    c_we_c    = 1'b0;
    c_wa      = cidx;
    c_wd      = t_q;
    v_we_c    = 1'b0;
    div_go    = 1'b0;
    call_go   = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (d_full) err = ERR_OVERFLOW;
        else begin
          d_we_c    = 1'b1;
          dcnt_next = dcnt + DCW'(1);
        end
      end
      OP_POP: begin
        if (d_lt1) err = ERR_UNDERFLOW;
        else dcnt_next = dcnt_m1;
      end
      OP_DUP: begin
        if (d_lt1) err = ERR_UNDERFLOW;
        else if (d_full) err = ERR_OVERFLOW;
        else begin
          d_we_c    = 1'b1;
          d_wd      = t_q;
          dcnt_next = dcnt + DCW'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (d_lt2) err = ERR_UNDERFLOW;
        else if (op_q == OP_DIV && t_tag == TAG_NUM && s_tag == TAG_NUM && t_val == '0)
          err = ERR_DIV_ZERO;
        else if (t_tag != TAG_NUM || s_tag != TAG_NUM) begin
          err       = ERR_TAG;
          dcnt_next = dcnt_m2;
        end else begin
          dcnt_next = dcnt_m1;
          d_we_c    = 1'b1;
          d_wa      = dcnt_m2[DAW-1:0];
          d_wd      = {TAG_NUM, alu};
          div_go    = (op_q == OP_DIV);
        end
      end
      OP_JMP: nip = arg_q[15:0];
      OP_JIT, OP_JIF: begin
        if (d_lt1) err = ERR_UNDERFLOW;
        else begin
          dcnt_next = dcnt_m1;
          if ((t_val != '0) == (op_q == OP_JIT)) nip = arg_q[15:0];
        end
      end
      OP_CALL: begin
        if (call_fault) err = ERR_CALL;
        else begin
          call_go   = 1'b1;
          c_we_c    = 1'b1;
          c_wa      = ccnt[CAW-1:0];
          c_wd      = {TAG_NUM, W'(fb)};
          ccnt_next = ccnt + CCW'(2);
          nip       = arg_q[15:0];
        end
      end
      OP_RET: begin
        if (ccnt < CCW'(2)) err = ERR_CALL;
        else begin
          nip       = 16'(32'(c1_q[W-1:0]) + 32'd1);
          fb_next   = 16'(32'(c_rdata[W-1:0]));
          ccnt_next = ccnt_m2;
        end
      end
      OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE: begin
        if (d_lt2) err = ERR_UNDERFLOW;
        else begin
          dcnt_next = dcnt_m1;
          d_we_c    = 1'b1;
          d_wa      = dcnt_m2[DAW-1:0];
          d_wd      = {TAG_NUM, W'(cmp_r)};
        end
      end
      OP_STO: begin
        if (!mem_ok) err = ERR_INDEX;
        else if (d_lt1) err = ERR_UNDERFLOW;
        else begin
          v_we_c    = 1'b1;
          dcnt_next = dcnt_m1;
        end
      end
      OP_RCL: begin
        if (!mem_ok) err = ERR_INDEX;
        else if (d_full) err = ERR_OVERFLOW;
        else begin
          d_we_c    = 1'b1;
          d_wd      = v_q;
          dcnt_next = dcnt + DCW'(1);
        end
      end
      OP_END: begin
        halt_c = 1'b1;
        nip    = ip;
      end
      OP_PRN: begin
        if (d_lt1) err = ERR_UNDERFLOW;
        else begin
          dcnt_next = dcnt_m1;
          pv_c      = 1'b1;
          ptag_c    = t_tag;
          pval_c    = 32'($signed(t_val));
        end
      end
      OP_STL: begin
        if (!ix_ok) err = ERR_INDEX;
        else if (d_lt1) err = ERR_UNDERFLOW;
        else begin
          c_we_c    = 1'b1;
          dcnt_next = dcnt_m1;
        end
      end
      OP_RCE: begin
        if (!ix_ok) err = ERR_INDEX;
        else if (d_full) err = ERR_OVERFLOW;
        else begin
          d_we_c    = 1'b1;
          d_wd      = c1_q;
          dcnt_next = dcnt + DCW'(1);
        end
      end
      OP_ALC, OP_FRE: begin
        if (!nc_ok) err = ERR_CALL;
        else begin
          if (op_q == OP_ALC) fb_next = 16'(32'(ccnt) - 32'd1);
          ccnt_next = nc[CCW-1:0];
        end
      end
      default: err = ERR_UNSUP;
    endcase
  end

  // write enables
  assign d_we    = cmd.commit && !spent && d_we_c;
  assign v_we    = cmd.commit && !spent && v_we_c;
  assign c_we    = (cmd.commit && !spent && c_we_c) || cmd.call2;
  assign c_waddr = cmd.call2 ? ccnt_m1[CAW-1:0] : c_wa;
  assign c_wdata = cmd.call2 ? {TAG_NUM, W'(ip_old)} : c_wd;

  // read addresses: top entries first, then the ones below
  assign d_raddr = cmd.decode ? dcnt_m1[DAW-1:0] : dcnt_m2[DAW-1:0];
  assign c_raddr = cmd.decode ? ((op_q == OP_RCE) ? cidx : ccnt_m1[CAW-1:0])
                              : ccnt_m2[CAW-1:0];

  // data stack
  always_ff @(posedge clk) begin
    if (d_we) dmem[d_wa] <= d_wd;
    d_rdata <= dmem[d_raddr];
  end

  // call and frame stack
  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rdata <= cmem[c_raddr];
  end

  // variable memory
  always_ff @(posedge clk) begin
    if (v_we) vmem[arg_q[MAW-1:0]] <= t_q;
    v_rdata <= vmem[arg_q[MAW-1:0]];
  end

  // instruction capture and first operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      tag_q  <= arg_type;
      arg_q  <= arg_value;
      ip_old <= ip;
    end
    if (cmd.read) begin
      t_q  <= d_rdata;
      c1_q <= c_rdata;
      v_q  <= v_rdata;
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ip    <= '0;
      fb    <= '0;
      dcnt  <= '0;
      ccnt  <= '0;
      steps <= '0;
      limit <= 32'hFFFF_FFFF;
    end else begin
      if (cfg_write) limit <= cfg_data;
      if (cmd.commit && !spent) begin
        ip    <= nip;
        fb    <= fb_next;
        dcnt  <= dcnt_next;
        ccnt  <= ccnt_next;
        steps <= steps + 32'd1;
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (spent) begin
        res_nip    <= ip;
        res_pv     <= 1'b0;
        res_ptag   <= 3'd0;
        res_pval   <= 32'd0;
        res_halt   <= 1'b0;
        res_budget <= 1'b1;
        res_err    <= ERR_NONE;
      end else begin
        res_nip    <= nip;
        res_pv     <= pv_c;
        res_ptag   <= ptag_c;
        res_pval   <= pval_c;
        res_halt   <= halt_c;
        res_budget <= ({1'b0, steps} + 33'd1) >= {1'b0, limit};
        res_err    <= err;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      next_ip     <= res_nip;
      print_valid <= res_pv;
      print_tag   <= res_ptag;
      print_value <= res_pval;
      halted      <= res_halt;
      budget_done <= res_budget;
      error_code  <= res_err;
    end
  end

  // status
  always_comb begin
    sts          = '0;
    sts.div_go   = div_go && !spent;
    sts.call_go  = call_go && !spent;
    sts.div_done = div_done;
    sts.out_free = !out_valid || out_ready;
  end

  a_dcnt_range: assert property (@(posedge clk) disable iff (rst)
    dcnt <= DCW'(DATA_STACK_DEPTH)) else $error("data stack count out of range");
  a_ccnt_range: assert property (@(posedge clk) disable iff (rst)
    ccnt <= CCW'(CALL_STACK_DEPTH)) else $error("call stack count out of range");
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finished result not presented");

endmodule

`default_nettype wire

### rtl/core/stack_machine_interpreter.sv
// Stack machine interpreter: executes one fetched instruction per request.
// Input channel (in_valid/in_ready) carries opcode, arg_type and arg_value;
// output channel (out_valid/out_ready) returns next_ip, the print fields,
// halted, budget_done and error_code for that instruction.
// cfg_write/cfg_data load the step limit; write it only while idle.
// Each instruction passes from acceptance through the decode, read and
// execute states to a done state that loads out_valid; CALL adds a state
// for the second call stack word on the single write port, and DIV waits
// in a divide state for the restoring divider, one quotient bit a cycle.
// The stacks read through one registered port each, so the top and second
// entries are read in turn; a request is taken only in the idle state.
// A new request is taken while the previous result still waits in the
// output register; a stalled receiver holds the result and, once the next
// one is ready, holds in_ready low.
// Reset (synchronous, active high) clears the instruction pointer, frame
// base, stack counts and step counter and sets the step limit to all ones.
// Stack and variable memories are not cleared; read them only once written.
`default_nettype none

module stack_machine_interpreter
  import smi_pkg::*;
#(
  parameter int DATA_STACK_DEPTH = 64,
  parameter int CALL_STACK_DEPTH = 128,
  parameter int MEM_DEPTH        = 128,
  parameter int VALUE_WIDTH      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [4:0]         opcode,
  input  wire logic [2:0]         arg_type,
  input  wire logic signed [31:0] arg_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             next_ip,
  output logic                    print_valid,
  output logic [2:0]              print_tag,
  output logic signed [31:0]      print_value,
  output logic                    halted,
  output logic                    budget_done,
  output logic [2:0]              error_code
);

  cmd_t cmd;
  sts_t sts;

  smi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smi_dp #(
    .DATA_STACK_DEPTH (DATA_STACK_DEPTH),
    .CALL_STACK_DEPTH (CALL_STACK_DEPTH),
    .MEM_DEPTH        (MEM_DEPTH),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .arg_type    (arg_type),
    .arg_value   (arg_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_ip     (next_ip),
    .print_valid (print_valid),
    .print_tag   (print_tag),
    .print_value (print_value),
    .halted      (halted),
    .budget_done (budget_done),
    .error_code  (error_code)
  );

endmodule

`default_nettype wire
